// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by top_k_score_tracker; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked at every rising edge while reset is released.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Checked at every rising edge, reset included.
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop)
`define ASSERT_CLK(lbl, clk, prop)
`endif

`endif

// ----- design/tkst_pkg.sv -----
// ----------------------------------------------------------------------------
// tkst_pkg
// Shared types and codes of the top-K score tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package tkst_pkg;

  // Item kinds carried in tuser.
  localparam logic [1:0] KIND_OFFER = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Register indexes (byte address bits [3:2]).
  localparam logic [1:0] REG_LIST_SIZE  = 2'd0;
  localparam logic [1:0] REG_MIN_LENGTH = 2'd1;
  localparam logic [1:0] REG_INIT_THR   = 2'd2;

  localparam logic [6:0]  LIST_SIZE_RST  = 7'd16;
  localparam logic [3:0]  MIN_LENGTH_RST = 4'd3;
  localparam logic [31:0] INIT_THR_RST   = 32'h0001_0000;

  // One list entry as held in the store.
  typedef struct packed {
    logic [31:0] score;
    logic [31:0] id;
  } entry_t;

endpackage

`default_nettype wire

// ----- design/top_k_score_tracker.sv -----
// ----------------------------------------------------------------------------
// top_k_score_tracker
// Keeps the K best candidates in descending score order (Q16.16 scores).
// ----------------------------------------------------------------------------
// Items enter on the in_ stream: tuser carries the kind (offer, read, clear),
// tdata the candidate and the read index. Every item yields exactly one
// result item on the out_ stream with the flags, the threshold and fill count
// after the step, and the entry that a read asks for.
// The list lives in a single-port-write, registered-read RAM. An offer that
// enters the list walks it from the bottom up, one entry per cycle, shifting
// smaller entries down one place until the insertion point is found. An offer
// that enters a non-empty list goes through the walk, and the place state if
// it shifts every held entry, before the hand-over state. One placed into an
// empty list or a list of size one, a clear, a rejected offer or an unknown
// kind goes straight there, and a read through the read-data state first.
// One item is in work at a time; in_tready is high only while the
// sequencer is idle.
// The finished result sits in an output register; while the receiver stalls
// the sequencer waits with the result and takes no new item. A new item may
// be accepted while the previous result still waits to be taken.
// Reset empties the list, restores the register defaults and the threshold.
// Write the registers over the APB-style cfg_ port only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module top_k_score_tracker
  import tkst_pkg::*;
#(
  parameter int MAX_K = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Input stream
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata: candidate_score[31:0], candidate_id[63:32],
  //        candidate_length[67:64], read_index[73:68], zero[79:74]
  input  wire logic [79:0]  in_tdata,
  // tuser: kind[1:0]
  input  wire logic [1:0]   in_tuser,
  // Result stream
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tdata: above_threshold[0], inserted[1], current_threshold[33:2],
  //        fill_count[40:34], entry_valid[41], entry_score[73:42],
  //        entry_id[105:74], zero[111:106]
  output logic [111:0]      out_tdata,
  // Configuration port
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [3:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int HW = $clog2(MAX_K + 1);
  localparam int CW = (HW > 7) ? HW : 7;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WALK  = 3'd1;
  localparam logic [2:0] ST_PLACE = 3'd2;
  localparam logic [2:0] ST_RDATA = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  // Configuration registers
  logic [6:0]  list_size_r;
  logic [3:0]  min_length_r;
  logic [31:0] init_thr_r;

  // List state
  logic [HW-1:0] held_r;
  logic [31:0]   thr_r;

  // Sequencer
  logic [2:0]    state_r;
  logic [31:0]   score_r;
  logic [31:0]   id_r;
  logic [AW-1:0] j_r;
  logic [AW-1:0] h_r;
  logic          first_r;
  logic [31:0]   last_r;
  logic          above_r;
  logic          ins_r;
  logic          valid_r;
  logic [31:0]   ent_score_r;
  logic [31:0]   ent_id_r;

  // Output register
  logic          out_valid_r;
  logic [111:0]  out_data_r;

  // RAM ports
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_entry;
  logic [AW-1:0] rd_addr;
  entry_t        rd_entry;

  // Input fields
  logic [1:0]  in_kind;
  logic [31:0] in_score;
  logic [31:0] in_id;
  logic [3:0]  in_length;
  logic [5:0]  in_ridx;

  assign in_kind   = in_tuser;
  assign in_score  = in_tdata[31:0];
  assign in_id     = in_tdata[63:32];
  assign in_length = in_tdata[67:64];
  assign in_ridx   = in_tdata[73:68];

  logic          in_acc;
  logic [CW-1:0] k_eff;
  logic [CW-1:0] h_new;
  logic          offer_ins;
  logic          walk_shift;
  logic [31:0]   fin_last;
  logic          fin_full;
  logic          out_free;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // List size 0 acts as one, anything above MAX_K as MAX_K.
  always_comb begin
    priority if (list_size_r == 7'd0) begin
      k_eff = CW'(1);
    end else if (CW'(list_size_r) > CW'(MAX_K)) begin
      k_eff = CW'(MAX_K);
    end else begin
      k_eff = CW'(list_size_r);
    end
  end

  // A full list (or one left over-full by a lowered K) drops to K-1 first.
  assign h_new     = (CW'(held_r) >= k_eff) ? (k_eff - CW'(1)) : CW'(held_r);
  assign offer_ins = (in_score > thr_r) && (in_length >= min_length_r);

  // During the walk the RAM output holds entry j_r.
  assign walk_shift = (rd_entry.score < score_r);
  // Score that ends up at the last position, h_r, of the grown list.
  always_comb begin
    if (!first_r) begin
      fin_last = last_r;
    end else if (state_r == ST_WALK && walk_shift) begin
      fin_last = rd_entry.score;
    end else begin
      fin_last = score_r;
    end
  end
  assign fin_full = ((CW'(h_r) + CW'(1)) == k_eff);

  // RAM control
  always_comb begin
    wr_en          = 1'b0;
    wr_addr        = j_r + AW'(1);
    wr_entry.score = score_r;
    wr_entry.id    = id_r;
    rd_addr        = j_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_kind == KIND_OFFER && offer_ins) begin
          if (h_new == CW'(0)) begin
            wr_en          = 1'b1;
            wr_addr        = '0;
            wr_entry.score = in_score;
            wr_entry.id    = in_id;
          end else begin
            rd_addr = AW'(h_new - CW'(1));
          end
        end else if (in_acc && in_kind == KIND_READ) begin
          rd_addr = AW'(in_ridx);
        end
      end
      ST_WALK: begin
        wr_en = 1'b1;
        if (walk_shift) begin
          wr_entry = rd_entry;
          rd_addr  = j_r - AW'(1);
        end
      end
      ST_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = '0;
      end
      ST_RDATA, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  tkst_entry_ram #(
    .DEPTH (MAX_K),
    .AW    (AW)
  ) u_ram (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  // Sequencer and list state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= '0;
      thr_r       <= INIT_THR_RST;
      out_valid_r <= 1'b0;
    end else begin
      // In the hand-over state a taken result is replaced by the next one.
      if (out_tready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            score_r     <= in_score;
            id_r        <= in_id;
            above_r     <= (in_kind == KIND_OFFER) && (in_score > thr_r);
            ins_r       <= (in_kind == KIND_OFFER) && offer_ins;
            valid_r     <= (in_kind == KIND_READ) && (CW'(in_ridx) < CW'(held_r));
            ent_score_r <= '0;
            ent_id_r    <= '0;
            first_r     <= 1'b1;
            h_r         <= AW'(h_new);
            j_r         <= AW'(h_new - CW'(1));
            unique case (in_kind)
              KIND_OFFER: begin
                if (offer_ins && h_new != CW'(0)) begin
                  state_r <= ST_WALK;
                end else begin
                  state_r <= ST_DONE;
                  if (offer_ins) begin
                    held_r <= HW'(1);
                    if (k_eff == CW'(1)) begin
                      thr_r <= in_score;
                    end
                  end
                end
              end
              KIND_READ: begin
                state_r <= ST_RDATA;
              end
              KIND_CLEAR: begin
                held_r  <= '0;
                thr_r   <= init_thr_r;
                state_r <= ST_DONE;
              end
              default: begin
                state_r <= ST_DONE;
              end
            endcase
          end
        end
        ST_WALK: begin
          if (walk_shift) begin
            first_r <= 1'b0;
            if (first_r) begin
              last_r <= rd_entry.score;
            end
            j_r <= j_r - AW'(1);
            if (j_r == '0) begin
              state_r <= ST_PLACE;
            end
          end else begin
            held_r <= HW'(CW'(h_r) + CW'(1));
            if (fin_full) begin
              thr_r <= fin_last;
            end
            state_r <= ST_DONE;
          end
        end
        ST_PLACE: begin
          held_r <= HW'(CW'(h_r) + CW'(1));
          if (fin_full) begin
            thr_r <= fin_last;
          end
          state_r <= ST_DONE;
        end
        ST_RDATA: begin
          if (valid_r) begin
            ent_score_r <= rd_entry.score;
            ent_id_r    <= rd_entry.id;
          end
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {6'd0, ent_id_r, ent_score_r, valid_r, 7'(held_r),
                            thr_r, ins_r, above_r};
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Configuration port
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_size_r  <= LIST_SIZE_RST;
      min_length_r <= MIN_LENGTH_RST;
      init_thr_r   <= INIT_THR_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LIST_SIZE:  list_size_r  <= cfg_pwdata[6:0];
        REG_MIN_LENGTH: min_length_r <= cfg_pwdata[3:0];
        REG_INIT_THR:   init_thr_r   <= cfg_pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_LIST_SIZE:  cfg_prdata = {25'd0, list_size_r};
      REG_MIN_LENGTH: cfg_prdata = {28'd0, min_length_r};
      REG_INIT_THR:   cfg_prdata = init_thr_r;
      default:        cfg_prdata = '0;
    endcase
  end

  // The list never holds more than MAX_K entries.
  `ASSERT_CLK_RST(a_held_bound, clk, rst_n, (CW'(held_r) <= CW'(MAX_K)))
  // The walk stays above the end of the list it is growing.
  `ASSERT_CLK_RST(a_walk_index, clk, rst_n, (state_r == ST_WALK) |-> (j_r < h_r))
  // No store write while a result is being handed over.
  `ASSERT_CLK_RST(a_done_quiet, clk, rst_n, (state_r == ST_DONE) |-> !wr_en)
  // A new result only comes out of the hand-over state.
  `ASSERT_CLK_RST(a_result_src, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == ST_DONE))

endmodule

`default_nettype wire

// ----- design/tkst_entry_ram.sv -----
// ----------------------------------------------------------------------------
// tkst_entry_ram
// Entry store: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tkst_entry_ram
  import tkst_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_entry,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_entry
);

  entry_t mem [DEPTH];
  entry_t rd_entry_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    rd_entry_r <= mem[rd_addr];
  end

  assign rd_entry = rd_entry_r;

endmodule

`default_nettype wire
